>>> hw/rtl/rdc_pkg.sv
// rdc_pkg: shared types and constants for the range distinct-count block
// no dependencies; compiled first
`default_nettype none

package rdc_pkg;

    // default sizes of the two stores
    localparam int DEF_MAX_ELEMENTS = 1024;
    localparam int DEF_VALUE_RANGE  = 1024;

    // fixed field widths on the channels
    localparam int VALUE_W  = 10;
    localparam int LEFT_W   = 11;
    localparam int COUNT_W  = 11;
    localparam int STATUS_W = 2;

    // request kinds
    typedef enum logic {
        REQ_APPEND = 1'b0,
        REQ_QUERY  = 1'b1
    } req_kind_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_BAD  = 2'd2
    } status_t;

    // tree walk operations
    typedef enum logic [1:0] {
        OP_INC = 2'd0,
        OP_DEC = 2'd1,
        OP_ADD = 2'd2,
        OP_SUB = 2'd3
    } walk_op_t;

    // command from the sequencer to the walk unit
    typedef struct packed {
        logic     start;
        walk_op_t op;
    } walk_cmd_t;

    // status from the walk unit to the sequencer
    typedef struct packed {
        logic idle;
        logic done;
    } walk_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/rdc_req_if.sv
// rdc_req_if: request channel (append or query word)
// depends on rdc_pkg
`default_nettype none

interface rdc_req_if;
    import rdc_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 req_type;
    logic [VALUE_W-1:0]   value;
    logic [LEFT_W-1:0]    left_bound;

    modport source (output valid, req_type, value, left_bound, input ready);
    modport sink   (input valid, req_type, value, left_bound, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/rdc_rsp_if.sv
// rdc_rsp_if: result channel (distinct count and status word)
// depends on rdc_pkg
`default_nettype none

interface rdc_rsp_if;
    import rdc_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [COUNT_W-1:0]   distinct_count;
    logic [STATUS_W-1:0]  status;

    modport source (output valid, distinct_count, status, input ready);
    modport sink   (input valid, distinct_count, status, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/rdc_ram.sv
// rdc_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module rdc_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 16,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> hw/rtl/rdc_walker.sv
// rdc_walker: fenwick tree store and the unit that walks it, one node per cycle
// depends on rdc_pkg and rdc_ram
`default_nettype none

module rdc_walker #(
    parameter int  MAX_ELEMENTS = rdc_pkg::DEF_MAX_ELEMENTS,
    localparam int SUM_W        = $clog2(MAX_ELEMENTS + 1),
    localparam int IDX_W        = SUM_W + 1,
    localparam int AW           = $clog2(MAX_ELEMENTS)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  rdc_pkg::walk_cmd_t cmd,
    input  logic [IDX_W-1:0]   start_idx,
    input  logic               clr_en,
    input  logic [AW-1:0]      clr_addr,
    output rdc_pkg::walk_stat_t stat,
    output logic [SUM_W-1:0]   sum
);
    import rdc_pkg::*;

    logic             busy_reg, busy_next;
    logic             pend_reg, pend_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    walk_op_t         op_reg, op_next;
    logic [AW-1:0]    pend_addr_reg, pend_addr_next;
    logic [SUM_W-1:0] acc_reg, acc_next;

    logic             in_range;
    logic             is_upd;
    logic             issue;
    logic             done;
    logic [IDX_W-1:0] low_bit;
    logic [IDX_W-1:0] idx_m1;
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [SUM_W-1:0] ram_wdata;
    logic [SUM_W-1:0] ram_rdata;

    // tree node store, node i lives at address i-1
    rdc_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_ELEMENTS)
    ) u_tree (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_m1[AW-1:0]),
        .rdata (ram_rdata)
    );

    // walk step: read node now, modify and write it back when data returns.
    // consecutive nodes of one walk differ, and a new walk reads no earlier
    // than the cycle after the last write lands, so no forwarding is needed
    always_comb
    begin
        in_range = (idx_reg != '0) && (idx_reg <= IDX_W'(MAX_ELEMENTS));
        low_bit  = idx_reg & (~idx_reg + IDX_W'(1));
        idx_m1   = idx_reg - IDX_W'(1);
        is_upd   = (op_reg == OP_INC) || (op_reg == OP_DEC);
        issue    = busy_reg && in_range;
        done     = busy_reg && !in_range;

        busy_next      = busy_reg;
        idx_next       = idx_reg;
        op_next        = op_reg;
        pend_next      = issue;
        pend_addr_next = idx_m1[AW-1:0];
        acc_next       = acc_reg;

        if (done)
        begin
            busy_next = 1'b0;
        end
        if (issue)
        begin
            idx_next = is_upd ? (idx_reg + low_bit) : (idx_reg - low_bit);
        end

        // accumulate prefix sums
        if (pend_reg && (op_reg == OP_ADD))
        begin
            acc_next = acc_reg + ram_rdata;
        end
        else if (pend_reg && (op_reg == OP_SUB))
        begin
            acc_next = acc_reg - ram_rdata;
        end

        // new walk
        if (cmd.start)
        begin
            busy_next = 1'b1;
            idx_next  = start_idx;
            op_next   = cmd.op;
            if (cmd.op == OP_ADD)
            begin
                acc_next = '0;
            end
        end
    end

    // write back or clear
    always_comb
    begin
        ram_we    = clr_en || (pend_reg && is_upd);
        ram_waddr = clr_en ? clr_addr : pend_addr_reg;
        if (clr_en)
        begin
            ram_wdata = '0;
        end
        else if (op_reg == OP_INC)
        begin
            ram_wdata = ram_rdata + SUM_W'(1);
        end
        else
        begin
            ram_wdata = ram_rdata - SUM_W'(1);
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pend_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            pend_reg <= pend_next;
        end
    end

    // walk payload registers
    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        op_reg        <= op_next;
        pend_addr_reg <= pend_addr_next;
        acc_reg       <= acc_next;
    end

    assign stat.idle = !busy_reg;
    assign stat.done = done;
    assign sum       = acc_reg;

endmodule

`default_nettype wire

>>> hw/rtl/range_distinct_count_fenwick.sv
// range_distinct_count_fenwick: top level, request sequencer and last-position store
// depends on rdc_pkg, rdc_req_if, rdc_rsp_if, rdc_ram and rdc_walker
`default_nettype none

// Counts distinct values in positions left_bound..count of an appended
// sequence. An append word moves the mark of its value from its previous
// position to the new last position; a query word returns the number of
// marks from left_bound to the end. Each word takes one result word. After
// reset both stores are swept to zero, one entry per cycle; no request is
// taken meanwhile. The tree memory does one node access per cycle, which sets
// the rate. An append reads the last position of its value, decrements the
// tree from that position if the value was seen before, then increments it
// from the new position; a query sums the tree through the end and then
// subtracts the sum through left_bound - 1. A full append or a bad left bound
// goes straight to the result. The result word shows up in the same cycle
// that the next word can be taken. One result may wait on the output while
// the next word is taken.
module range_distinct_count_fenwick #(
    parameter int MAX_ELEMENTS = rdc_pkg::DEF_MAX_ELEMENTS,
    parameter int VALUE_RANGE  = rdc_pkg::DEF_VALUE_RANGE
) (
    input  logic       clk,
    input  logic       rst_n,
    rdc_req_if.sink    req,
    rdc_rsp_if.source  rsp
);
    import rdc_pkg::*;

    localparam int POS_W     = $clog2(MAX_ELEMENTS + 1);
    localparam int IDX_W     = POS_W + 1;
    localparam int TREE_AW   = $clog2(MAX_ELEMENTS);
    localparam int VAL_AW    = $clog2(VALUE_RANGE);
    localparam int CLR_DEPTH = (MAX_ELEMENTS > VALUE_RANGE) ? MAX_ELEMENTS : VALUE_RANGE;
    localparam int CLR_W     = $clog2(CLR_DEPTH);

    typedef enum logic [7:0] {
        S_CLEAR  = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_LAST   = 8'b0000_0100,
        S_DOWN   = 8'b0000_1000,
        S_UP     = 8'b0001_0000,
        S_SUM_HI = 8'b0010_0000,
        S_SUM_LO = 8'b0100_0000,
        S_FIN    = 8'b1000_0000
    } state_t;

    state_t             state_reg, state_next;
    logic [CLR_W-1:0]   clr_reg, clr_next;
    logic [POS_W-1:0]   count_reg, count_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [POS_W-1:0]   lm1_reg, lm1_next;
    logic [VAL_AW-1:0]  val_reg, val_next;
    req_kind_t          kind_reg, kind_next;
    status_t            res_status_reg, res_status_next;
    logic               rsp_valid_reg, rsp_valid_next;
    logic [COUNT_W-1:0] rsp_count_reg, rsp_count_next;
    status_t            rsp_status_reg, rsp_status_next;

    logic               accept;
    logic               out_free;
    logic [31:0]        val_wide;
    logic [31:0]        val_sat;
    logic [31:0]        left_wide;
    logic [31:0]        left_m1;
    logic [31:0]        count_wide;
    logic [31:0]        clr_wide;
    logic [31:0]        acc_wide;

    walk_cmd_t          wcmd;
    walk_stat_t         wstat;
    logic [IDX_W-1:0]   wstart_idx;
    logic [POS_W-1:0]   wsum;
    logic               tree_clr_en;

    logic               lp_we;
    logic [VAL_AW-1:0]  lp_waddr;
    logic [POS_W-1:0]   lp_wdata;
    logic [POS_W-1:0]   lp_old;

    // last position of each value, zero means never seen
    rdc_ram #(
        .WIDTH (POS_W),
        .DEPTH (VALUE_RANGE)
    ) u_last (
        .clk   (clk),
        .we    (lp_we),
        .waddr (lp_waddr),
        .wdata (lp_wdata),
        .raddr (val_sat[VAL_AW-1:0]),
        .rdata (lp_old)
    );

    // fenwick tree of marks and its walk unit
    rdc_walker #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_walk (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (wcmd),
        .start_idx (wstart_idx),
        .clr_en    (tree_clr_en),
        .clr_addr  (clr_reg[TREE_AW-1:0]),
        .stat      (wstat),
        .sum       (wsum)
    );

    // request decode helpers
    always_comb
    begin
        val_wide   = 32'(req.value);
        val_sat    = (val_wide >= 32'(VALUE_RANGE)) ? 32'(VALUE_RANGE - 1) : val_wide;
        left_wide  = 32'(req.left_bound);
        left_m1    = left_wide - 32'd1;
        count_wide = 32'(count_reg);
        clr_wide   = 32'(clr_reg);
        acc_wide   = 32'(wsum);
    end

    assign req.ready = (state_reg == S_IDLE) && wstat.idle;
    assign accept    = req.valid && req.ready;
    assign out_free  = !rsp_valid_reg || rsp.ready;

    // last-position store write
    always_comb
    begin
        lp_we    = ((state_reg == S_CLEAR) && (clr_wide < 32'(VALUE_RANGE)))
                   || (state_reg == S_LAST);
        lp_waddr = (state_reg == S_CLEAR) ? clr_reg[VAL_AW-1:0] : val_reg;
        lp_wdata = (state_reg == S_CLEAR) ? '0 : pos_reg;
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        count_next      = count_reg;
        pos_next        = pos_reg;
        lm1_next        = lm1_reg;
        val_next        = val_reg;
        kind_next       = kind_reg;
        res_status_next = res_status_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        rsp_count_next  = rsp_count_reg;
        rsp_status_next = rsp_status_reg;
        wcmd.start      = 1'b0;
        wcmd.op         = OP_INC;
        wstart_idx      = '0;
        tree_clr_en     = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                tree_clr_en = clr_wide < 32'(MAX_ELEMENTS);
                clr_next    = clr_reg + CLR_W'(1);
                if (clr_reg == CLR_W'(CLR_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    kind_next       = req_kind_t'(req.req_type);
                    val_next        = val_sat[VAL_AW-1:0];
                    pos_next        = count_reg + POS_W'(1);
                    lm1_next        = left_m1[POS_W-1:0];
                    res_status_next = ST_OK;
                    if (req_kind_t'(req.req_type) == REQ_APPEND)
                    begin
                        if (count_wide >= 32'(MAX_ELEMENTS))
                        begin
                            res_status_next = ST_FULL;
                            state_next      = S_FIN;
                        end
                        else
                        begin
                            state_next = S_LAST;
                        end
                    end
                    else if ((left_wide == 32'd0) || (left_wide > count_wide))
                    begin
                        res_status_next = ST_BAD;
                        state_next      = S_FIN;
                    end
                    else
                    begin
                        wcmd.start = 1'b1;
                        wcmd.op    = OP_ADD;
                        wstart_idx = {1'b0, count_reg};
                        state_next = S_SUM_HI;
                    end
                end
            end
            S_LAST:
            begin
                // old position read back, new one written this cycle
                wcmd.start = 1'b1;
                if (lp_old != '0)
                begin
                    wcmd.op    = OP_DEC;
                    wstart_idx = {1'b0, lp_old};
                    state_next = S_DOWN;
                end
                else
                begin
                    wcmd.op    = OP_INC;
                    wstart_idx = {1'b0, pos_reg};
                    state_next = S_UP;
                end
            end
            S_DOWN:
            begin
                if (wstat.done)
                begin
                    wcmd.start = 1'b1;
                    wcmd.op    = OP_INC;
                    wstart_idx = {1'b0, pos_reg};
                    state_next = S_UP;
                end
            end
            S_UP:
            begin
                if (wstat.done)
                begin
                    count_next = pos_reg;
                    state_next = S_FIN;
                end
            end
            S_SUM_HI:
            begin
                if (wstat.done)
                begin
                    wcmd.start = 1'b1;
                    wcmd.op    = OP_SUB;
                    wstart_idx = {1'b0, lm1_reg};
                    state_next = S_SUM_LO;
                end
            end
            S_SUM_LO:
            begin
                if (wstat.done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = res_status_reg;
                    if ((kind_reg == REQ_QUERY) && (res_status_reg == ST_OK))
                    begin
                        rsp_count_next = acc_wide[COUNT_W-1:0];
                    end
                    else
                    begin
                        rsp_count_next = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pos_reg        <= pos_next;
        lm1_reg        <= lm1_next;
        val_reg        <= val_next;
        kind_reg       <= kind_next;
        res_status_reg <= res_status_next;
        rsp_count_reg  <= rsp_count_next;
        rsp_status_reg <= rsp_status_next;
    end

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.distinct_count = rsp_count_reg;
    assign rsp.status         = rsp_status_reg;

endmodule

`default_nettype wire

>>> hw/rtl/rdc_checker.sv
// rdc_checker: port-level assertions for the range distinct-count block
// depends on rdc_pkg; bound to range_distinct_count_fenwick
`default_nettype none

module rdc_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         req_valid,
    input logic                         req_ready,
    input logic                         rsp_valid,
    input logic                         rsp_ready,
    input logic [rdc_pkg::COUNT_W-1:0]  rsp_count,
    input logic [rdc_pkg::STATUS_W-1:0] rsp_status
);
    import rdc_pkg::*;

    logic [1:0] pend_reg, pend_next;
    logic       req_acc;
    logic       rsp_acc;

    // words taken but not yet answered
    assign req_acc = req_valid && req_ready;
    assign rsp_acc = rsp_valid && rsp_ready;

    always_comb
    begin
        pend_next = pend_reg;
        if (req_acc && !rsp_acc)
        begin
            pend_next = pend_reg + 2'd1;
        end
        else if (!req_acc && rsp_acc)
        begin
            pend_next = pend_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    // an error result carries no count
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status != ST_OK) |-> (rsp_count == '0))
        else $error("error result with nonzero count");

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_count) && $stable(rsp_status))
        else $error("stalled result changed");

    // no result without an open request
    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (pend_reg != 2'd0))
        else $error("result with no open request");

    // at most one word in work and one result waiting
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |-> (pend_reg != 2'd3))
        else $error("too many open requests");

endmodule

bind range_distinct_count_fenwick rdc_checker u_rdc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_count  (rsp.distinct_count),
    .rsp_status (rsp.status)
);

`default_nettype wire

>>> tb/rdc_result_check.sv
// rdc_result_check: watches the request and result channels, predicts every result word
// and compares it with what the block returns; depends on rdc_pkg, rdc_req_if, rdc_rsp_if
`default_nettype none

module rdc_result_check
    import rdc_pkg::*;
#(
    parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS,
    parameter int VALUE_RANGE  = DEF_VALUE_RANGE
) (
    input  logic clk,
    input  logic rst_n,
    rdc_req_if   req,
    rdc_rsp_if   rsp,
    output int   mismatches,
    output int   outstanding
);

    typedef struct packed {
        logic [COUNT_W-1:0] distinct_count;
        status_t            status;
    } result_word_t;

    // fenwick sums of the marks, last position of each value, sequence length
    int unsigned  mark_sums [1:MAX_ELEMENTS];
    int unsigned  last_seen_pos [0:VALUE_RANGE-1];
    int unsigned  seq_len;

    result_word_t awaited_results [$];

    // move one mark up or down the tree from a position
    function automatic void move_mark(input int unsigned pos, input bit up);
        int unsigned i;
        i = pos;
        while (i != 0 && i <= MAX_ELEMENTS)
        begin
            if (up)
                mark_sums[i] = mark_sums[i] + 1;
            else
                mark_sums[i] = mark_sums[i] - 1;
            i = i + (i & (~i + 1));
        end
    endfunction

    // number of marks in positions 1..pos
    function automatic int unsigned marks_through(input int unsigned pos);
        int unsigned i;
        int unsigned sum;
        sum = 0;
        i = (pos > MAX_ELEMENTS) ? MAX_ELEMENTS : pos;
        while (i != 0)
        begin
            sum = sum + mark_sums[i];
            i = i - (i & (~i + 1));
        end
        return sum;
    endfunction

    // apply one request word and return the result word it should produce
    function automatic result_word_t predict_result(input req_kind_t kind,
                                                    input logic [VALUE_W-1:0] val,
                                                    input logic [LEFT_W-1:0] lb);
        result_word_t res;
        int unsigned  v;
        int unsigned  newpos;
        res.distinct_count = '0;
        res.status         = ST_OK;
        if (kind == REQ_APPEND)
        begin
            if (seq_len >= MAX_ELEMENTS)
            begin
                res.status = ST_FULL;
            end
            else
            begin
                v = val;
                if (v >= VALUE_RANGE)
                    v = VALUE_RANGE - 1;
                newpos = seq_len + 1;
                if (last_seen_pos[v] != 0)
                    move_mark(last_seen_pos[v], 1'b0);
                last_seen_pos[v] = newpos;
                move_mark(newpos, 1'b1);
                seq_len = newpos;
            end
        end
        else if (lb == 0 || lb > seq_len)
        begin
            res.status = ST_BAD;
        end
        else
        begin
            res.distinct_count = COUNT_W'(marks_through(seq_len)
                                          - marks_through(int'(lb) - 1));
        end
        return res;
    endfunction

    // result words are checked before the request of the same edge is predicted
    always @(posedge clk or negedge rst_n)
    begin
        result_word_t due;
        int           bad;
        if (!rst_n)
        begin
            for (int i = 1; i <= MAX_ELEMENTS; i++)
                mark_sums[i] = 0;
            for (int i = 0; i < VALUE_RANGE; i++)
                last_seen_pos[i] = 0;
            seq_len = 0;
            awaited_results.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            bad = 0;
            if (rsp.valid && rsp.ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    $display("%0t: unexpected result word, expected none, got count %0d status %0d",
                             $time, rsp.distinct_count, rsp.status);
                    bad++;
                end
                else
                begin
                    due = awaited_results.pop_front();
                    if (rsp.distinct_count !== due.distinct_count)
                    begin
                        $display("%0t: distinct_count expected %0d, got %0d",
                                 $time, due.distinct_count, rsp.distinct_count);
                        bad++;
                    end
                    if (rsp.status !== due.status)
                    begin
                        $display("%0t: status expected %0d, got %0d",
                                 $time, due.status, rsp.status);
                        bad++;
                    end
                end
            end
            if (req.valid && req.ready)
                awaited_results.push_back(predict_result(req_kind_t'(req.req_type),
                                                         req.value, req.left_bound));
            if (bad != 0)
                mismatches <= mismatches + bad;
            outstanding <= awaited_results.size();
        end
    end

endmodule

`default_nettype wire

>>> tb/testbench.sv
// testbench: drives append and query words into range_distinct_count_fenwick with random
// pacing and gives the verdict; depends on rdc_pkg, both channel interfaces, rdc_result_check
`default_nettype none

module testbench;
    import rdc_pkg::*;

    localparam int MAX_LEN      = DEF_MAX_ELEMENTS;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 60;

    logic clk;
    logic rst_n;
    int   mismatches;
    int   outstanding;
    int   fill_level;
    int   cycles;
    bit   src_calm;
    int   calm_left;

    rdc_req_if req_ch ();
    rdc_rsp_if rsp_ch ();

    range_distinct_count_fenwick dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    rdc_result_check result_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("range_distinct_count_fenwick verification failed");
                $finish;
            end
        end
    end

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // values drawn mostly from small pools so that repeats are common
    function automatic logic [VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return VALUE_W'($urandom_range(0, 7));
        if (r < 70)
            return VALUE_W'($urandom_range(0, 63));
        return VALUE_W'($urandom);
    endfunction

    // left bounds mostly in 1..fill_level, some out of range
    function automatic logic [LEFT_W-1:0] pick_left();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)
            return '0;
        if (r < 8)
            return LEFT_W'(fill_level + 1);
        if (r < 12)
            return LEFT_W'($urandom_range(fill_level + 1, 2047));
        if (r < 25)
            return LEFT_W'(1);
        if (r < 40)
            return LEFT_W'(fill_level);
        return LEFT_W'($urandom_range(1, (fill_level > 0) ? fill_level : 1));
    endfunction

    // result side: random stalls, with calm windows of steady ready
    initial
    begin
        int stall;
        int window;
        bit sink_calm;
        stall        = 0;
        window       = 0;
        sink_calm    = 1'b0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (window == 0)
            begin
                sink_calm = ($urandom_range(0, 3) == 0);
                window    = $urandom_range(100, 400);
            end
            window--;
            if (stall > 0)
            begin
                stall--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                if (!sink_calm)
                    stall = pick_gap();
            end
        end
    end

    // send one request word, idling first, and wait for its handshake
    task automatic send_word(input req_kind_t kind, input logic [VALUE_W-1:0] val,
                             input logic [LEFT_W-1:0] lb);
        int gap;
        if (calm_left <= 0)
        begin
            src_calm  = ($urandom_range(0, 3) == 0);
            calm_left = $urandom_range(20, 80);
        end
        calm_left--;
        gap = src_calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= kind;
        req_ch.value      <= val;
        req_ch.left_bound <= lb;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        if (kind == REQ_APPEND && fill_level < MAX_LEN)
            fill_level++;
    endtask

    // one random word, append with the given percentage; unused fields random
    task automatic random_word(input int append_pct);
        if ($urandom_range(0, 99) < append_pct)
            send_word(REQ_APPEND, pick_value(), LEFT_W'($urandom));
        else
            send_word(REQ_QUERY, VALUE_W'($urandom), pick_left());
    endtask

    // hold the request side until every result word is back; the count
    // is registered, so it settles after the last handshake
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    initial
    begin
        rst_n             = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.req_type   = REQ_APPEND;
        req_ch.value      = '0;
        req_ch.left_bound = '0;
        fill_level        = 0;
        src_calm          = 1'b0;
        calm_left         = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // queries on an empty sequence all take the bad bound path
        send_word(REQ_QUERY, '0, '0);
        send_word(REQ_QUERY, '1, LEFT_W'(1));
        send_word(REQ_QUERY, '0, '1);

        // extreme values and repeats that move a mark
        send_word(REQ_APPEND, '0, '0);
        send_word(REQ_APPEND, '1, '1);
        send_word(REQ_APPEND, '0, '0);
        send_word(REQ_APPEND, '1, '0);
        send_word(REQ_APPEND, VALUE_W'(682), '0);
        send_word(REQ_APPEND, VALUE_W'(341), '1);

        // bounds at and around the ends of the sequence
        send_word(REQ_QUERY, '0, LEFT_W'(1));
        send_word(REQ_QUERY, '1, LEFT_W'(6));
        send_word(REQ_QUERY, '0, LEFT_W'(7));
        send_word(REQ_QUERY, '0, '0);
        send_word(REQ_QUERY, '0, LEFT_W'(1024));
        send_word(REQ_QUERY, '0, LEFT_W'(1025));
        send_word(REQ_QUERY, '0, LEFT_W'(3));
        send_word(REQ_APPEND, VALUE_W'(341), '0);
        send_word(REQ_QUERY, '0, LEFT_W'(2));
        send_word(REQ_QUERY, '0, LEFT_W'(7));

        // mixed traffic, then a full drain
        repeat (100) random_word(60);
        drain_results();

        // mostly appends until the sequence is full
        while (fill_level < MAX_LEN)
            random_word(95);

        // full sequence: appends are dropped, bounds reach the top
        send_word(REQ_QUERY, '0, LEFT_W'(MAX_LEN));
        send_word(REQ_QUERY, '0, LEFT_W'(1));
        send_word(REQ_QUERY, '0, LEFT_W'(MAX_LEN + 1));
        send_word(REQ_APPEND, '1, '0);
        send_word(REQ_APPEND, '0, '1);
        repeat (30) random_word(50);

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("range_distinct_count_fenwick verification clean");
        else
            $display("range_distinct_count_fenwick verification failed");
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
hw/rtl/rdc_pkg.sv
hw/rtl/rdc_req_if.sv
hw/rtl/rdc_rsp_if.sv
hw/rtl/rdc_ram.sv
hw/rtl/rdc_walker.sv
hw/rtl/range_distinct_count_fenwick.sv
hw/rtl/rdc_checker.sv
tb/rdc_result_check.sv
tb/testbench.sv
